// File: hdl/pvca_pkg.sv
// Shared types, constants and scan-order functions for the priority voice
// channel allocator. No dependencies; every other file of the block uses it.
`default_nettype none

package pvca_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_W       = $clog2(NUM_CHANNELS);
    localparam int PRI_W        = 8;
    localparam int VOL_W        = 11;

    localparam logic [VOL_W-1:0] FULL_VOLUME = 11'h7FF;

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_WRITE = 1'b1;

    localparam logic [1:0] CLASS_PCM   = 2'd0;
    localparam logic [1:0] CLASS_TONE  = 2'd1;
    localparam logic [1:0] CLASS_NOISE = 2'd2;
    localparam logic [1:0] CLASS_BAD   = 2'd3;

    typedef struct packed {
        logic              op;
        logic [1:0]        chan_class;
        logic [PRI_W-1:0]  request_priority;
        logic [CHAN_W-1:0] target_channel;
        logic [PRI_W-1:0]  new_priority;
        logic [VOL_W-1:0]  new_volume;
    } t_in_word;

    typedef struct packed {
        logic              granted;
        logic [CHAN_W-1:0] channel_index;
        logic              bad_class;
    } t_out_word;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [VOL_W-1:0] vol;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // take the input word; a write item updates its channel
        logic rd_en;     // read the channel at the current scan position
        logic decide;    // settle the grant and, on a grant, write back full volume
        logic out_load;  // move the finished result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_write;   // input word is a write item
        logic is_bad;     // input word is an allocate item of the invalid class
        logic scan_last;  // current scan position is the last of its class
        logic out_free;   // output register can take a result this cycle
    } t_status;

    // Channel visited at a scan position for each class.
    function automatic logic [CHAN_W-1:0] scan_chan(input logic [1:0] cls,
                                                    input logic [CHAN_W-1:0] idx);
        logic [CHAN_W-1:0] ch;
        ch = '0;
        case (cls)
            CLASS_PCM: begin
                case (idx)
                    4'd0:    ch = 4'd4;
                    4'd1:    ch = 4'd5;
                    4'd2:    ch = 4'd6;
                    4'd3:    ch = 4'd7;
                    4'd4:    ch = 4'd2;
                    4'd5:    ch = 4'd0;
                    4'd6:    ch = 4'd3;
                    4'd7:    ch = 4'd1;
                    4'd8:    ch = 4'd8;
                    4'd9:    ch = 4'd9;
                    4'd10:   ch = 4'd10;
                    4'd11:   ch = 4'd11;
                    4'd12:   ch = 4'd14;
                    4'd13:   ch = 4'd12;
                    4'd14:   ch = 4'd15;
                    default: ch = 4'd13;
                endcase
            end
            CLASS_TONE:  ch = 4'd8 + idx;
            CLASS_NOISE: ch = 4'd14 + idx;
            default:     ch = '0;
        endcase
        return ch;
    endfunction

    // Last scan position of each class.
    function automatic logic [CHAN_W-1:0] scan_last_idx(input logic [1:0] cls);
        logic [CHAN_W-1:0] last;
        case (cls)
            CLASS_PCM:   last = 4'd15;
            CLASS_TONE:  last = 4'd5;
            CLASS_NOISE: last = 4'd1;
            default:     last = 4'd0;
        endcase
        return last;
    endfunction

endpackage

`default_nettype wire

// File: hdl/pvca_ctrl.sv
// Controller state machine of the allocator: sequences accept, scan,
// decision and result hand-off. Depends on pvca_pkg.
`default_nettype none

module pvca_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire pvca_pkg::t_status i_status,
    output logic                   o_in_stall,
    output pvca_pkg::t_cmd         o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_RESP   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = accept;
        o_cmd.rd_en    = (r_state == ST_SCAN);
        o_cmd.decide   = (r_state == ST_DECIDE);
        o_cmd.out_load = (r_state == ST_RESP) && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_status.is_write || i_status.is_bad) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_RESP;
            ST_RESP: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: hdl/pvca_datapath.sv
// Datapath of the allocator: channel state memory, scan compare, grant
// decision and output register. Depends on pvca_pkg.
`default_nettype none

module pvca_datapath (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire pvca_pkg::t_in_word  i_in_word,
    input  wire pvca_pkg::t_cmd      i_cmd,
    input  wire                      i_out_stall,
    output pvca_pkg::t_status        o_status,
    output logic                     o_out_valid,
    output pvca_pkg::t_out_word      o_out_word
);

    localparam int CW = pvca_pkg::CHAN_W;
    localparam int PW = pvca_pkg::PRI_W;
    localparam int VW = pvca_pkg::VOL_W;

    // Channel state: one write port, one registered read port.
    pvca_pkg::t_entry              r_mem [pvca_pkg::NUM_CHANNELS];
    logic [pvca_pkg::NUM_CHANNELS-1:0] r_valid;

    pvca_pkg::t_in_word  r_item;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       rd_addr;

    pvca_pkg::t_entry    r_rd_data;
    logic                r_rd_hit;
    logic                r_rd_vld;
    logic                r_rd_first;
    logic [CW-1:0]       r_rd_ch;
    pvca_pkg::t_entry    rd_entry;

    logic [PW-1:0]       r_best_pri;
    logic [VW-1:0]       r_best_vol;
    logic [CW-1:0]       r_best_ch;
    logic                better;
    logic                grant;

    logic                wr_en;
    logic [CW-1:0]       wr_addr;
    pvca_pkg::t_entry    wr_data;

    pvca_pkg::t_out_word r_res;
    pvca_pkg::t_out_word r_out;
    logic                r_out_vld;

    assign rd_addr  = pvca_pkg::scan_chan(r_item.chan_class, r_idx);
    assign rd_entry = r_rd_hit ? r_rd_data : '0;
    assign grant    = (r_item.request_priority >= r_best_pri);

    // Later channels replace the pick only on lower priority, or on equal
    // priority with strictly lower volume.
    assign better = r_rd_first
                 || (rd_entry.pri < r_best_pri)
                 || ((rd_entry.pri == r_best_pri) && (rd_entry.vol < r_best_vol));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = i_in_word.target_channel;
        wr_data.pri = i_in_word.new_priority;
        wr_data.vol = i_in_word.new_volume;
        if (i_cmd.accept && (i_in_word.op == pvca_pkg::OP_WRITE)) begin
            wr_en = 1'b1;
        end else if (i_cmd.decide && grant) begin
            wr_en       = 1'b1;
            wr_addr     = r_best_ch;
            wr_data.pri = r_best_pri;
            wr_data.vol = pvca_pkg::FULL_VOLUME;
        end
    end

    always_comb begin
        o_status           = '0;
        o_status.is_write  = (i_in_word.op == pvca_pkg::OP_WRITE);
        o_status.is_bad    = (i_in_word.op == pvca_pkg::OP_ALLOC)
                          && (i_in_word.chan_class == pvca_pkg::CLASS_BAD);
        o_status.scan_last = (r_idx == pvca_pkg::scan_last_idx(r_item.chan_class));
        o_status.out_free  = !r_out_vld || !i_out_stall;
    end

    // Memory array, no reset; entries never written read as zero via r_valid.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // Item, scan position and read tag.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_word;
            r_idx  <= '0;
        end else if (i_cmd.rd_en) begin
            r_idx  <= r_idx + 1'b1;
        end
        if (i_cmd.rd_en) begin
            r_rd_hit   <= r_valid[rd_addr];
            r_rd_first <= (r_idx == '0);
            r_rd_ch    <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    // Running best candidate.
    always_ff @(posedge i_clk) begin
        if (r_rd_vld && better) begin
            r_best_pri <= rd_entry.pri;
            r_best_vol <= rd_entry.vol;
            r_best_ch  <= r_rd_ch;
        end
    end

    // Pending result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res.granted       <= 1'b0;
            r_res.channel_index <= '0;
            r_res.bad_class     <= o_status.is_bad;
        end else if (i_cmd.decide) begin
            r_res.granted       <= grant;
            r_res.channel_index <= grant ? r_best_ch : '0;
            r_res.bad_class     <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    a_no_read_during_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.rd_en && wr_en))
        else $error("channel memory read and write in the same cycle");

    a_grant_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.granted && r_out.bad_class))
        else $error("result both granted and flagged as bad class");

    a_idle_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.granted) |-> (r_out.channel_index == '0))
        else $error("refused result carries a nonzero channel index");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_vld || !i_out_stall))
        else $error("output register overwritten while a result waits");

endmodule

`default_nettype wire

// File: hdl/priority_voice_channel_allocator.sv
// Top level of the priority voice channel allocator: joins the controller
// and the datapath. Depends on pvca_pkg, pvca_ctrl and pvca_datapath.
//
//   Channel | Direction | Payload type          | Handshake
//   --------+-----------+-----------------------+---------------------------
//   in      | into      | pvca_pkg::t_in_word   | i_in_valid / o_in_stall
//   out     | out of    | pvca_pkg::t_out_word  | o_out_valid / i_out_stall
//
// A write word or an invalid-class allocate word goes from acceptance straight
// to the result state. An allocate word reads its class one channel per cycle,
// then passes the drain and decide states before the result state.
// One word is worked on at a time; the input stalls until the result has
// moved into the output register, which then waits for the receiver.
// Synchronous active-low reset clears the controller, output valid and valid bits.
`default_nettype none

module priority_voice_channel_allocator (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire pvca_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output pvca_pkg::t_out_word      o_out_word
);

    // Commands flow from the controller, status flows back.
    pvca_pkg::t_cmd    cmd;
    pvca_pkg::t_status status;

    pvca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    pvca_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire
